// ===== src/i2c_master_slave_transfer_sequencer_top_defines.svh =====
// Assertion macros for the I2C transfer sequencer.
// Used by the modules that carry assertions; expects clk and arst_n in scope.
`ifndef I2C_MASTER_SLAVE_TRANSFER_SEQUENCER_TOP_DEFINES_SVH
`define I2C_MASTER_SLAVE_TRANSFER_SEQUENCER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define I2CMSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define I2CMSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/i2cmss_pkg.sv =====
// Shared types and constants for the I2C transfer sequencer.
// No dependencies; used by i2cmss_dp, i2cmss_ctrl and the top level.
package i2cmss_pkg;

	localparam int BUFFER_DEPTH = 32;

	// Remainder unit for the slave transmit wrap: one quotient bit per step
	localparam int DIV_STEPS = 7;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		OP_EVENT = 3'd0,
		OP_ERROR = 3'd1,
		OP_START = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		CTRL_NONE       = 3'd0,
		CTRL_NO_ACK     = 3'd1,
		CTRL_STOP       = 3'd2,
		CTRL_START      = 3'd3,
		CTRL_CLEAR_STOP = 3'd4
	} ctrl_t;

	typedef enum logic [1:0] {
		FAULT_NONE = 2'd0,
		FAULT_NACK = 2'd1,
		FAULT_BUS  = 2'd2
	} fault_t;

	typedef enum logic {
		CFG_SLAVE_TX_LENGTH = 1'b0,
		CFG_SLAVE_RX_LENGTH = 1'b1
	} cfg_idx_t;

	// event_flags bit positions
	localparam int EV_START_SENT = 0;
	localparam int EV_ADDR_MATCH = 1;
	localparam int EV_BYTE_RX    = 2;
	localparam int EV_TX_EMPTY   = 3;
	localparam int EV_STOP_SEEN  = 4;

	// error_flags bit positions
	localparam int ERR_NACK = 2;
	localparam int ERR_ARB  = 3;
	localparam int ERR_BUS  = 4;

	localparam logic [5:0] LEN_RESET = 6'd32;

	typedef struct packed {
		logic [2:0] operation;
		logic [4:0] event_flags;
		logic [4:0] error_flags;
		logic       master_role;
		logic       transmitter_role;
		logic [7:0] received_byte;
		logic [7:0] target_address;
		logic [5:0] transfer_length;
		logic       buffer_select;
		logic [4:0] buffer_index;
		logic [7:0] write_data;
	} item_t;

	typedef struct packed {
		logic [7:0] send_byte;
		logic       send_valid;
		logic [2:0] control_action;
		logic [4:0] flag_clear;
		logic       master_busy_out;
		logic [1:0] master_error_out;
		logic       slave_tx_busy_out;
		logic       slave_rx_busy_out;
		logic       tx_prepare_pulse;
		logic       rx_full_pulse;
		logic [7:0] read_data;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic mod_step;
		logic mod_last;
		logic load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic mod_needed;
	} status_t;

endpackage

// ===== src/i2cmss_if.sv =====
// Channel interfaces of the I2C transfer sequencer: input items, result items
// and configuration writes. Depends on nothing.
interface i2cmss_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [4:0] event_flags;
	logic [4:0] error_flags;
	logic       master_role;
	logic       transmitter_role;
	logic [7:0] received_byte;
	logic [7:0] target_address;
	logic [5:0] transfer_length;
	logic       buffer_select;
	logic [4:0] buffer_index;
	logic [7:0] write_data;

	modport source (
		output valid, operation, event_flags, error_flags, master_role, transmitter_role,
		output received_byte, target_address, transfer_length, buffer_select,
		output buffer_index, write_data,
		input  ready
	);
	modport sink (
		input  valid, operation, event_flags, error_flags, master_role, transmitter_role,
		input  received_byte, target_address, transfer_length, buffer_select,
		input  buffer_index, write_data,
		output ready
	);
endinterface

interface i2cmss_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] send_byte;
	logic       send_valid;
	logic [2:0] control_action;
	logic [4:0] flag_clear;
	logic       master_busy_out;
	logic [1:0] master_error_out;
	logic       slave_tx_busy_out;
	logic       slave_rx_busy_out;
	logic       tx_prepare_pulse;
	logic       rx_full_pulse;
	logic [7:0] read_data;

	modport source (
		output valid, send_byte, send_valid, control_action, flag_clear, master_busy_out,
		output master_error_out, slave_tx_busy_out, slave_rx_busy_out, tx_prepare_pulse,
		output rx_full_pulse, read_data,
		input  ready
	);
	modport sink (
		input  valid, send_byte, send_valid, control_action, flag_clear, master_busy_out,
		input  master_error_out, slave_tx_busy_out, slave_rx_busy_out, tx_prepare_pulse,
		input  rx_full_pulse, read_data,
		output ready
	);
endinterface

interface i2cmss_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [5:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/i2cmss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2cmss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/i2cmss_dp.sv =====
// Datapath: transfer state, the three byte buffers, the wrap remainder unit
// and the result register. Depends on i2cmss_pkg, i2cmss_if and i2cmss_ram.
module i2cmss_dp #(
	parameter int BUFFER_DEPTH = i2cmss_pkg::BUFFER_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2cmss_pkg::item_t    item,
	input  i2cmss_pkg::cmd_t     cmd,
	output i2cmss_pkg::status_t  status,
	output i2cmss_pkg::result_t  result,
	i2cmss_cfg_if.sink           cfg_ch
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	typedef enum logic [1:0] {
		SRC_NONE,
		SRC_TGT,
		SRC_MEM
	} src_t;

	typedef enum logic [1:0] {
		RD_MASTER,
		RD_SLV_TX,
		RD_SLV_RX
	} rd_sel_t;

	// Architectural state
	logic [5:0] pos_q, tgt_len_q, tx_len_q, rx_len_q;
	logic [7:0] tgt_q;
	logic       act_q, ss_q, sr_q;
	logic [1:0] fault_q;

	// Pending result parts, held from accept to load
	src_t       send_src_q;
	rd_sel_t    rd_sel_q;
	logic       rd_ok_q, rd_to_data_q, prep_q, full_q;
	logic [2:0] ctrl_q;
	logic [4:0] clr_q;

	// Remainder unit
	logic [6:0] div_rem_q, div_num_q, div_trial, div_next;

	i2cmss_pkg::result_t res_q;

	// Next-state values for one item
	logic [5:0] pos_n, len_n;
	logic [7:0] tgt_n;
	logic       act_n, ss_n, sr_n;
	logic [1:0] fault_n;
	src_t       send_src;
	rd_sel_t    rd_sel;
	logic       rd_en, rd_ok, rd_to_data, prep, full, mod_needed;
	logic [2:0] ctrl;
	logic [4:0] clr;
	logic [6:0] dividend;
	logic [AW-1:0] rd_addr;

	// Buffer ports
	logic          m_we, t_we, r_we;
	logic [AW-1:0] m_wa, t_wa, r_wa;
	logic [7:0]    m_wd, t_wd, r_wd;
	logic [7:0]    m_rd, t_rd, r_rd, mem_byte;

	function automatic logic in_range(logic [5:0] p);
		return int'(p) < BUFFER_DEPTH;
	endfunction

	// Item decode: events in their fixed order, later actions win
	always_comb begin
		pos_n      = pos_q;
		tgt_n      = tgt_q;
		len_n      = tgt_len_q;
		act_n      = act_q;
		fault_n    = fault_q;
		ss_n       = ss_q;
		sr_n       = sr_q;
		send_src   = SRC_NONE;
		rd_sel     = RD_MASTER;
		rd_en      = 1'b0;
		rd_ok      = 1'b0;
		rd_to_data = 1'b0;
		rd_addr    = '0;
		prep       = 1'b0;
		full       = 1'b0;
		ctrl       = i2cmss_pkg::CTRL_NONE;
		clr        = '0;
		mod_needed = 1'b0;
		dividend   = '0;
		m_we = 1'b0; m_wa = '0; m_wd = '0;
		t_we = 1'b0; t_wa = '0; t_wd = '0;
		r_we = 1'b0; r_wa = '0; r_wd = '0;
		case (i2cmss_pkg::op_t'(item.operation))
			i2cmss_pkg::OP_EVENT: begin
				if (item.event_flags[i2cmss_pkg::EV_START_SENT]) begin
					send_src = SRC_TGT;
					if (!item.transmitter_role && tgt_len_q == 6'd1) begin
						ctrl = i2cmss_pkg::CTRL_NO_ACK;
					end
				end
				if (item.event_flags[i2cmss_pkg::EV_ADDR_MATCH]) begin
					pos_n = '0;
					if (!item.master_role) begin
						if (item.transmitter_role) begin
							ss_n = 1'b1;
							prep = 1'b1;
						end else begin
							sr_n = 1'b1;
						end
					end
				end
				if (item.event_flags[i2cmss_pkg::EV_BYTE_RX]) begin
					if (item.master_role) begin
						m_we  = in_range(pos_n);
						m_wa  = AW'(pos_n);
						m_wd  = item.received_byte;
						pos_n = pos_n + 6'd1;
						if (pos_n == tgt_len_q) begin
							ctrl  = i2cmss_pkg::CTRL_STOP;
							act_n = 1'b0;
						end else if (pos_n == tgt_len_q - 6'd1) begin
							ctrl = i2cmss_pkg::CTRL_NO_ACK;
						end
					end else begin
						r_we  = in_range(pos_n);
						r_wa  = AW'(pos_n);
						r_wd  = item.received_byte;
						pos_n = pos_n + 6'd1;
						if (pos_n == rx_len_q) begin
							full  = 1'b1;
							pos_n = '0;
						end
					end
				end
				if (item.event_flags[i2cmss_pkg::EV_TX_EMPTY]) begin
					if (item.master_role) begin
						if (pos_n == tgt_len_q) begin
							ctrl  = i2cmss_pkg::CTRL_STOP;
							act_n = 1'b0;
						end else begin
							send_src = SRC_MEM;
							rd_sel   = RD_MASTER;
							rd_en    = 1'b1;
							rd_ok    = in_range(pos_n);
							rd_addr  = AW'(pos_n);
							pos_n    = pos_n + 6'd1;
						end
					end else begin
						send_src = SRC_MEM;
						rd_sel   = RD_SLV_TX;
						rd_en    = 1'b1;
						rd_ok    = in_range(pos_n);
						rd_addr  = AW'(pos_n);
						if (tx_len_q != '0) begin
							// wrap by the slave length goes to the remainder unit
							mod_needed = 1'b1;
							dividend   = {1'b0, pos_n} + 7'd1;
						end else begin
							pos_n = pos_n + 6'd1;
						end
					end
				end
				if (item.event_flags[i2cmss_pkg::EV_STOP_SEEN]) begin
					ctrl = i2cmss_pkg::CTRL_CLEAR_STOP;
					ss_n = 1'b0;
					sr_n = 1'b0;
				end
			end
			i2cmss_pkg::OP_ERROR: begin
				clr = item.error_flags;
				if (item.error_flags[i2cmss_pkg::ERR_NACK]) begin
					if (item.master_role) begin
						ctrl    = i2cmss_pkg::CTRL_STOP;
						fault_n = i2cmss_pkg::FAULT_NACK;
						act_n   = 1'b0;
					end else begin
						ss_n = 1'b0;
						sr_n = 1'b0;
					end
				end
				if (item.error_flags[i2cmss_pkg::ERR_ARB]) begin
					ctrl = i2cmss_pkg::CTRL_START;
				end
				if (item.error_flags[i2cmss_pkg::ERR_BUS]) begin
					act_n   = 1'b0;
					fault_n = i2cmss_pkg::FAULT_BUS;
					ss_n    = 1'b0;
					sr_n    = 1'b0;
				end
			end
			i2cmss_pkg::OP_START: begin
				if (!act_q) begin
					tgt_n   = item.target_address;
					len_n   = item.transfer_length;
					fault_n = i2cmss_pkg::FAULT_NONE;
					act_n   = 1'b1;
					ctrl    = i2cmss_pkg::CTRL_START;
				end
			end
			i2cmss_pkg::OP_WRITE: begin
				if (!item.buffer_select) begin
					m_we = in_range({1'b0, item.buffer_index});
					m_wa = AW'(item.buffer_index);
					m_wd = item.write_data;
				end else begin
					t_we = in_range({1'b0, item.buffer_index});
					t_wa = AW'(item.buffer_index);
					t_wd = item.write_data;
				end
			end
			i2cmss_pkg::OP_READ: begin
				rd_sel     = item.buffer_select ? RD_SLV_RX : RD_MASTER;
				rd_en      = 1'b1;
				rd_ok      = in_range({1'b0, item.buffer_index});
				rd_addr    = AW'(item.buffer_index);
				rd_to_data = 1'b1;
			end
			default: ;
		endcase
	end

	assign status.mod_needed = mod_needed;

	// Buffers; a write only ever happens on accept
	i2cmss_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_master_buf (
		.clk   (clk),
		.we    (cmd.accept && m_we),
		.waddr (m_wa),
		.wdata (m_wd),
		.re    (cmd.accept && rd_en && rd_sel == RD_MASTER),
		.raddr (rd_addr),
		.rdata (m_rd)
	);

	i2cmss_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_slave_tx_buf (
		.clk   (clk),
		.we    (cmd.accept && t_we),
		.waddr (t_wa),
		.wdata (t_wd),
		.re    (cmd.accept && rd_en && rd_sel == RD_SLV_TX),
		.raddr (rd_addr),
		.rdata (t_rd)
	);

	i2cmss_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_slave_rx_buf (
		.clk   (clk),
		.we    (cmd.accept && r_we),
		.waddr (r_wa),
		.wdata (r_wd),
		.re    (cmd.accept && rd_en && rd_sel == RD_SLV_RX),
		.raddr (rd_addr),
		.rdata (r_rd)
	);

	// One restoring step of the remainder
	always_comb begin
		div_trial = {div_rem_q[5:0], div_num_q[6]};
		if (div_trial >= {1'b0, tx_len_q}) begin
			div_next = div_trial - {1'b0, tx_len_q};
		end else begin
			div_next = div_trial;
		end
	end

	// Transfer state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			tgt_q     <= '0;
			tgt_len_q <= 6'd1;
			act_q     <= 1'b0;
			fault_q   <= i2cmss_pkg::FAULT_NONE;
			ss_q      <= 1'b0;
			sr_q      <= 1'b0;
			tx_len_q  <= i2cmss_pkg::LEN_RESET;
			rx_len_q  <= i2cmss_pkg::LEN_RESET;
		end else begin
			if (cfg_ch.valid) begin
				case (i2cmss_pkg::cfg_idx_t'(cfg_ch.index))
					i2cmss_pkg::CFG_SLAVE_TX_LENGTH: tx_len_q <= cfg_ch.data;
					i2cmss_pkg::CFG_SLAVE_RX_LENGTH: rx_len_q <= cfg_ch.data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				pos_q     <= pos_n;
				tgt_q     <= tgt_n;
				tgt_len_q <= len_n;
				act_q     <= act_n;
				fault_q   <= fault_n;
				ss_q      <= ss_n;
				sr_q      <= sr_n;
			end else if (cmd.mod_step && cmd.mod_last) begin
				pos_q <= div_next[5:0];
			end
		end
	end

	// writes are taken whenever reset is released
	assign cfg_ch.ready = arst_n;

	// Pending result parts and remainder registers (payload, no reset)
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			send_src_q   <= send_src;
			rd_sel_q     <= rd_sel;
			rd_ok_q      <= rd_ok;
			rd_to_data_q <= rd_to_data;
			prep_q       <= prep;
			full_q       <= full;
			ctrl_q       <= ctrl;
			clr_q        <= clr;
			div_rem_q    <= '0;
			div_num_q    <= dividend;
		end else if (cmd.mod_step) begin
			div_rem_q <= div_next;
			div_num_q <= {div_num_q[5:0], 1'b0};
		end
	end

	// Buffer byte for this item; entries past the buffer read as zero
	always_comb begin
		case (rd_sel_q)
			RD_MASTER: mem_byte = m_rd;
			RD_SLV_TX: mem_byte = t_rd;
			RD_SLV_RX: mem_byte = r_rd;
			default:   mem_byte = '0;
		endcase
		if (!rd_ok_q) begin
			mem_byte = '0;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (send_src_q)
				SRC_TGT: res_q.send_byte <= tgt_q;
				SRC_MEM: res_q.send_byte <= mem_byte;
				default: res_q.send_byte <= '0;
			endcase
			res_q.send_valid        <= send_src_q != SRC_NONE;
			res_q.control_action    <= ctrl_q;
			res_q.flag_clear        <= clr_q;
			res_q.master_busy_out   <= act_q;
			res_q.master_error_out  <= fault_q;
			res_q.slave_tx_busy_out <= ss_q;
			res_q.slave_rx_busy_out <= sr_q;
			res_q.tx_prepare_pulse  <= prep_q;
			res_q.rx_full_pulse     <= full_q;
			res_q.read_data         <= rd_to_data_q ? mem_byte : 8'd0;
		end
	end

	assign result = res_q;

endmodule

// ===== src/i2cmss_ctrl.sv =====
// Controller: item handshake, remainder step sequencing and result handshake.
// Depends on i2cmss_pkg and the assertion macro header.
`include "i2c_master_slave_transfer_sequencer_top_defines.svh"

module i2cmss_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	output logic                res_valid,
	input  logic                res_ready,
	input  i2cmss_pkg::status_t status,
	output i2cmss_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOD,
		S_LOAD
	} state_t;

	state_t                          state_q;
	logic [i2cmss_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                            res_valid_q;
	logic                            item_accept, out_free;

	// no item is taken while reset is held
	assign item_ready  = arst_n && state_q == S_IDLE;
	assign item_accept = item_valid && item_ready;
	assign out_free    = !res_valid_q || res_ready;

	// Commands to the datapath
	always_comb begin
		cmd.accept   = item_accept;
		cmd.mod_step = state_q == S_MOD;
		cmd.mod_last = cnt_q == '0;
		cmd.load     = state_q == S_LOAD && out_free;
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_accept) begin
						if (status.mod_needed) begin
							state_q <= S_MOD;
							cnt_q   <= i2cmss_pkg::DIV_CNT_W'(i2cmss_pkg::DIV_STEPS - 1);
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_MOD: begin
					if (cnt_q == '0) begin
						state_q <= S_LOAD;
					end else begin
						cnt_q <= cnt_q - i2cmss_pkg::DIV_CNT_W'(1);
					end
				end
				S_LOAD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;

	`I2CMSS_ASSERT_NEXT(a_one_item_at_a_time, item_accept, !item_ready, "item taken while busy")
	`I2CMSS_ASSERT_NEXT(a_wrap_to_div, item_accept && status.mod_needed, state_q == S_MOD, "wrap skipped")
	`I2CMSS_ASSERT_NEXT(a_load_shows_result, cmd.load, res_valid_q, "loaded result not shown")

endmodule

// ===== src/i2c_master_slave_transfer_sequencer_top.sv =====
// Top level of the I2C master/slave transfer sequencer.
// Depends on i2cmss_pkg, i2cmss_if, i2cmss_ctrl, i2cmss_dp and i2cmss_ram.
//
// Usage:
//   item_ch   takes one item per operation (bus event, bus error, master
//             start, buffer write, buffer read); valid/ready handshake.
//   result_ch returns exactly one result item per input item, in order.
//   cfg_ch    writes slave_tx_length (index 0) or slave_rx_length (index 1);
//             ready whenever out of reset, write only while the block is idle.
// Timing:
//   An accepted item goes to S_LOAD, which loads the result register when
//   the output is free; a slave transmit-empty event with a nonzero length
//   first runs S_MOD, as the index wrap uses a 7-step restoring remainder
//   unit, one bit per cycle. One item is in work at a time; the next item is
//   accepted while the previous result still waits in the output register.
// Reset:
//   arst_n clears the transfer state (target length to 1) and sets both
//   slave lengths to 32. Buffers are not cleared; no clearing pass is needed.
// Stalls:
//   While result_ch is stalled the result register holds and a finished
//   item waits in the controller until it frees.
module i2c_master_slave_transfer_sequencer_top #(
	parameter int BUFFER_DEPTH = i2cmss_pkg::BUFFER_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	i2cmss_item_if.sink     item_ch,
	i2cmss_result_if.source result_ch,
	i2cmss_cfg_if.sink      cfg_ch
);

	i2cmss_pkg::item_t   item;
	i2cmss_pkg::result_t result;
	i2cmss_pkg::cmd_t    cmd;
	i2cmss_pkg::status_t status;

	// Pack the input item
	always_comb begin
		item.operation        = item_ch.operation;
		item.event_flags      = item_ch.event_flags;
		item.error_flags      = item_ch.error_flags;
		item.master_role      = item_ch.master_role;
		item.transmitter_role = item_ch.transmitter_role;
		item.received_byte    = item_ch.received_byte;
		item.target_address   = item_ch.target_address;
		item.transfer_length  = item_ch.transfer_length;
		item.buffer_select    = item_ch.buffer_select;
		item.buffer_index     = item_ch.buffer_index;
		item.write_data       = item_ch.write_data;
	end

	i2cmss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_ch.valid),
		.item_ready (item_ch.ready),
		.res_valid  (result_ch.valid),
		.res_ready  (result_ch.ready),
		.status     (status),
		.cmd        (cmd)
	);

	i2cmss_dp #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result),
		.cfg_ch (cfg_ch)
	);

	// Unpack the result item
	assign result_ch.send_byte         = result.send_byte;
	assign result_ch.send_valid        = result.send_valid;
	assign result_ch.control_action    = result.control_action;
	assign result_ch.flag_clear        = result.flag_clear;
	assign result_ch.master_busy_out   = result.master_busy_out;
	assign result_ch.master_error_out  = result.master_error_out;
	assign result_ch.slave_tx_busy_out = result.slave_tx_busy_out;
	assign result_ch.slave_rx_busy_out = result.slave_rx_busy_out;
	assign result_ch.tx_prepare_pulse  = result.tx_prepare_pulse;
	assign result_ch.rx_full_pulse     = result.rx_full_pulse;
	assign result_ch.read_data         = result.read_data;

endmodule
